[sv/p2p_pkg.sv]
// Shared types, codes and constants of the peer message header checker.
`timescale 1ns / 1ps
`default_nettype none

package p2p_pkg;

  localparam int unsigned MAGIC_LEN  = 4;
  localparam int unsigned LENGTH_LEN = 4;
  localparam int unsigned SUM_LEN    = 4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NET_MAGIC      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BLOCK_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TX_SIZE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RECV       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEGACY_LIMIT   = 3'd4;

  localparam logic [31:0] RST_NET_MAGIC      = 32'd0;
  localparam logic [47:0] RST_MAX_BLOCK_SIZE = 48'd33554432;
  localparam logic [31:0] RST_MAX_TX_SIZE    = 32'd1000000;
  localparam logic [31:0] RST_MAX_RECV       = 32'd2097152;
  localparam logic [31:0] RST_LEGACY_LIMIT   = 32'd1048576;

  // Verdict codes
  localparam logic [1:0] VERDICT_OK       = 2'd0;
  localparam logic [1:0] VERDICT_MAGIC    = 2'd1;
  localparam logic [1:0] VERDICT_COMMAND  = 2'd2;
  localparam logic [1:0] VERDICT_OVERSIZE = 2'd3;

  // Command class codes
  localparam logic [2:0] CLS_PROTOCONF   = 3'd0;
  localparam logic [2:0] CLS_TX          = 3'd1;
  localparam logic [2:0] CLS_GETBLOCKTXN = 3'd2;
  localparam logic [2:0] CLS_BLOCK       = 3'd3;
  localparam logic [2:0] CLS_OTHER       = 3'd4;

  // Printable command characters
  localparam logic [7:0] CHR_MIN = 8'h20;
  localparam logic [7:0] CHR_MAX = 8'h7E;

  // Command texts, right-justified, first character in the highest used byte
  localparam logic [127:0] TXT_PROTOCONF   = 128'("protoconf");
  localparam logic [127:0] TXT_TX          = 128'("tx");
  localparam logic [127:0] TXT_GETBLOCKTXN = 128'("getblocktxn");
  localparam logic [127:0] TXT_BLOCK       = 128'("block");
  localparam logic [127:0] TXT_CMPCTBLOCK  = 128'("cmpctblock");
  localparam logic [127:0] TXT_BLOCKTXN    = 128'("blocktxn");
  localparam int unsigned LEN_PROTOCONF   = 9;
  localparam int unsigned LEN_TX          = 2;
  localparam int unsigned LEN_GETBLOCKTXN = 11;
  localparam int unsigned LEN_BLOCK       = 5;
  localparam int unsigned LEN_CMPCTBLOCK  = 10;
  localparam int unsigned LEN_BLOCKTXN    = 8;

  // Block size divided by the minimum transaction size, then scaled by short id size
  localparam logic [7:0]  MIN_TX_BYTES   = 8'd215;
  localparam logic [2:0]  SHORT_ID_BYTES = 3'd6;
  // Digit division: 16-bit digits, reciprocal of 215 scaled by 2^32 (exact below 2^24)
  localparam int unsigned DIG_W        = 16;
  localparam int unsigned DIV_NUM_W    = 24;
  localparam int unsigned DIV_RECIP_W  = 25;
  localparam int unsigned DIV_SHIFT    = 32;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 25'd19976593;

  typedef struct packed {
    logic [31:0] net_magic;
    logic [47:0] max_block_size;
    logic [31:0] max_tx_size;
    logic [31:0] max_recv_payload;
    logic [31:0] legacy_payload_limit;
  } cfg_t;

  typedef struct packed {
    logic        magic_ok;
    logic        cmd_bad;
    logic [2:0]  cls;
    logic [31:0] length;
  } hdr_sum_t;

endpackage

`default_nettype wire

[sv/p2p_ifs.sv]
// Handshake channels of the header checker: header bytes, verdicts, register writes.
`timescale 1ns / 1ps
`default_nettype none

interface p2p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  modport source (output valid, output header_byte, input ready);
  modport sink (input valid, input header_byte, output ready);
endinterface

interface p2p_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [31:0] payload_length;
  logic [2:0]  command_class;
  logic [47:0] length_limit;
  modport source (output valid, output verdict, output payload_length,
                  output command_class, output length_limit, input ready);
  modport sink (input valid, input verdict, input payload_length,
                input command_class, input length_limit, output ready);
endinterface

interface p2p_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [p2p_pkg::CFG_IDX_W-1:0]   index;
  logic [p2p_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/p2p_message_header_checker.sv]
// Peer message header checker: takes header bytes and gives one verdict per header.
//
// Channels: hdr_i takes one header byte per request in wire order (4 magic bytes,
// COMMAND_LEN command bytes, 4 length bytes little-endian, 4 checksum bytes).
// res_o gives one request per header: verdict, payload length, command class and
// the length limit applied. cfg_i writes the five configuration registers by index;
// unknown indexes are dropped. It is always ready.
// Throughput: one header byte per cycle, except when the last byte is held back as
// below. The verdict is registered on res_o after the last header byte is taken
// and the block-size divide by 215 (three 16-bit digits) has finished.
// The next header's bytes keep flowing while a verdict waits; only its last byte
// is held back while the previous verdict is still being computed or not taken.
// Reset returns to the first magic byte and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module p2p_message_header_checker #(
  parameter int unsigned COMMAND_LEN = 12
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  p2p_in_if.sink       hdr_i,
  p2p_out_if.source    res_o,
  p2p_cfg_if.sink      cfg_i
);

  localparam int unsigned HDR_LEN = p2p_pkg::MAGIC_LEN + COMMAND_LEN
                                    + p2p_pkg::LENGTH_LEN + p2p_pkg::SUM_LEN;

  p2p_pkg::cfg_t      cfg;
  p2p_pkg::hdr_sum_t  sum;
  logic               sum_valid;
  logic               last;
  logic               hdr_rdy;
  logic               hdr_acc;
  logic               div_done;
  logic [47:0]        quot;

  logic               run_q;
  logic               res_valid_q;
  logic [1:0]         verdict_q;
  logic [31:0]        length_q;
  logic [2:0]         cls_q;
  logic [47:0]        limit_q;

  logic [47:0]        gbt_limit;
  logic [47:0]        limit_d;
  logic [1:0]         verdict_d;

  assign hdr_rdy     = !(last && (run_q || res_valid_q));
  assign hdr_i.ready = hdr_rdy;
  assign hdr_acc     = hdr_i.valid && hdr_rdy;

  p2p_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  p2p_hdr_parse #(
    .COMMAND_LEN (COMMAND_LEN)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (hdr_acc),
    .byte_i      (hdr_i.header_byte),
    .net_magic_i (cfg.net_magic),
    .last_o      (last),
    .sum_valid_o (sum_valid),
    .sum_o       (sum)
  );

  p2p_blk_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sum_valid),
    .dividend_i (cfg.max_block_size),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // quotient * 6 + header length
  assign gbt_limit = 48'(quot << 2) + 48'(quot << 1) + 48'(HDR_LEN);

  always_comb begin
    unique case (sum.cls)
      p2p_pkg::CLS_PROTOCONF:   limit_d = {16'b0, cfg.legacy_payload_limit};
      p2p_pkg::CLS_TX:          limit_d = {16'b0, cfg.max_tx_size};
      p2p_pkg::CLS_GETBLOCKTXN: limit_d = gbt_limit;
      p2p_pkg::CLS_BLOCK:       limit_d = cfg.max_block_size;
      default:                  limit_d = {16'b0, cfg.max_recv_payload};
    endcase
    if (!sum.magic_ok) begin
      verdict_d = p2p_pkg::VERDICT_MAGIC;
    end else if (sum.cmd_bad) begin
      verdict_d = p2p_pkg::VERDICT_COMMAND;
    end else if ({16'b0, sum.length} > limit_d) begin
      verdict_d = p2p_pkg::VERDICT_OVERSIZE;
    end else begin
      verdict_d = p2p_pkg::VERDICT_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (sum_valid) run_q <= 1'b1;
      else if (div_done) run_q <= 1'b0;
      if (div_done) res_valid_q <= 1'b1;
      else if (res_o.ready) res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      verdict_q <= verdict_d;
      length_q  <= sum.length;
      cls_q     <= sum.cls;
      limit_q   <= limit_d;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.verdict        = verdict_q;
  assign res_o.payload_length = length_q;
  assign res_o.command_class  = cls_q;
  assign res_o.length_limit   = limit_q;

  a_done_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> !res_valid_q)
    else $error("verdict finished while previous one still pending");

  a_done_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |=> res_valid_q)
    else $error("finished verdict not presented");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hdr_i.ready |-> (run_q || res_valid_q))
    else $error("header byte held back with no verdict in flight");

  a_oversize: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.verdict == p2p_pkg::VERDICT_OVERSIZE))
      |-> ({16'b0, res_o.payload_length} > res_o.length_limit))
    else $error("oversize verdict with length inside limit");

endmodule

`default_nettype wire

[sv/p2p_cfg_regs.sv]
// Configuration register file of the header checker.
`timescale 1ns / 1ps
`default_nettype none

module p2p_cfg_regs (
  input  wire              clk_i,
  input  wire              rst_ni,
  p2p_cfg_if.sink          cfg_i,
  output p2p_pkg::cfg_t    cfg_o
);

  p2p_pkg::cfg_t cfg_q;
  logic          wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.net_magic            <= p2p_pkg::RST_NET_MAGIC;
      cfg_q.max_block_size       <= p2p_pkg::RST_MAX_BLOCK_SIZE;
      cfg_q.max_tx_size          <= p2p_pkg::RST_MAX_TX_SIZE;
      cfg_q.max_recv_payload     <= p2p_pkg::RST_MAX_RECV;
      cfg_q.legacy_payload_limit <= p2p_pkg::RST_LEGACY_LIMIT;
    end else if (wr) begin
      unique case (cfg_i.index)
        p2p_pkg::REG_NET_MAGIC:      cfg_q.net_magic            <= cfg_i.data[31:0];
        p2p_pkg::REG_MAX_BLOCK_SIZE: cfg_q.max_block_size       <= cfg_i.data;
        p2p_pkg::REG_MAX_TX_SIZE:    cfg_q.max_tx_size          <= cfg_i.data[31:0];
        p2p_pkg::REG_MAX_RECV:       cfg_q.max_recv_payload     <= cfg_i.data[31:0];
        p2p_pkg::REG_LEGACY_LIMIT:   cfg_q.legacy_payload_limit <= cfg_i.data[31:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/p2p_hdr_parse.sv]
// Byte-wise header parser: magic check, command store and checks, length field, class.
`timescale 1ns / 1ps
`default_nettype none

module p2p_hdr_parse #(
  parameter int unsigned COMMAND_LEN = 12
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                acc_i,
  input  wire  [7:0]         byte_i,
  input  wire  [31:0]        net_magic_i,
  output logic               last_o,
  output logic               sum_valid_o,
  output p2p_pkg::hdr_sum_t  sum_o
);

  localparam int unsigned CMD_START = p2p_pkg::MAGIC_LEN;
  localparam int unsigned LEN_START = CMD_START + COMMAND_LEN;
  localparam int unsigned SUM_START = LEN_START + p2p_pkg::LENGTH_LEN;
  localparam int unsigned HDR_LEN   = SUM_START + p2p_pkg::SUM_LEN;
  localparam int unsigned POS_W     = $clog2(HDR_LEN);
  localparam int unsigned CIDX_W    = $clog2(COMMAND_LEN);

  logic [POS_W-1:0]           pos_q;
  logic                       magic_ok_q;
  logic                       zero_seen_q;
  logic                       cmd_bad_q;
  logic                       sum_valid_q;
  logic [7:0]                 cmd_q [COMMAND_LEN];
  logic [7:0]                 len_q [p2p_pkg::LENGTH_LEN];
  p2p_pkg::hdr_sum_t          sum_q;

  logic                       in_magic;
  logic                       in_cmd;
  logic                       in_len;
  logic [7:0]                 magic_byte;
  logic                       printable;
  logic [CIDX_W-1:0]          cmd_idx;
  logic [1:0]                 len_lane;
  logic [8*COMMAND_LEN-1:0]   cmd_flat;
  logic [2:0]                 cls_d;

  // Stored command equals text of length n, followed by a zero unless it fills the field
  function automatic logic cmd_is(input logic [8*COMMAND_LEN-1:0] cmd,
                                  input logic [127:0] txt, input int unsigned n);
    logic ok;
    ok = (n <= COMMAND_LEN);
    for (int unsigned i = 0; i < COMMAND_LEN; i++) begin
      if (i < n) begin
        if (cmd[8*i +: 8] != txt[8*(n-1-i) +: 8]) ok = 1'b0;
      end else if (i == n) begin
        if (cmd[8*i +: 8] != 8'h00) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  assign in_magic   = pos_q < POS_W'(CMD_START);
  assign in_cmd     = !in_magic && (pos_q < POS_W'(LEN_START));
  assign in_len     = !in_magic && !in_cmd && (pos_q < POS_W'(SUM_START));
  assign magic_byte = net_magic_i[{pos_q[1:0], 3'b000} +: 8];
  assign printable  = (byte_i >= p2p_pkg::CHR_MIN) && (byte_i <= p2p_pkg::CHR_MAX);
  assign cmd_idx    = CIDX_W'(pos_q - POS_W'(CMD_START));
  assign len_lane   = 2'(pos_q - POS_W'(LEN_START));
  assign last_o     = pos_q == POS_W'(HDR_LEN - 1);

  always_comb begin
    for (int unsigned i = 0; i < COMMAND_LEN; i++) cmd_flat[8*i +: 8] = cmd_q[i];
  end

  always_comb begin
    if (cmd_is(cmd_flat, p2p_pkg::TXT_PROTOCONF, p2p_pkg::LEN_PROTOCONF)) begin
      cls_d = p2p_pkg::CLS_PROTOCONF;
    end else if (cmd_is(cmd_flat, p2p_pkg::TXT_TX, p2p_pkg::LEN_TX)) begin
      cls_d = p2p_pkg::CLS_TX;
    end else if (cmd_is(cmd_flat, p2p_pkg::TXT_GETBLOCKTXN, p2p_pkg::LEN_GETBLOCKTXN)) begin
      cls_d = p2p_pkg::CLS_GETBLOCKTXN;
    end else if (cmd_is(cmd_flat, p2p_pkg::TXT_BLOCK, p2p_pkg::LEN_BLOCK) ||
                 cmd_is(cmd_flat, p2p_pkg::TXT_CMPCTBLOCK, p2p_pkg::LEN_CMPCTBLOCK) ||
                 cmd_is(cmd_flat, p2p_pkg::TXT_BLOCKTXN, p2p_pkg::LEN_BLOCKTXN)) begin
      cls_d = p2p_pkg::CLS_BLOCK;
    end else begin
      cls_d = p2p_pkg::CLS_OTHER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      magic_ok_q  <= 1'b1;
      zero_seen_q <= 1'b0;
      cmd_bad_q   <= 1'b0;
      sum_valid_q <= 1'b0;
    end else begin
      sum_valid_q <= 1'b0;
      if (acc_i) begin
        if (last_o) begin
          pos_q       <= '0;
          magic_ok_q  <= 1'b1;
          zero_seen_q <= 1'b0;
          cmd_bad_q   <= 1'b0;
          sum_valid_q <= 1'b1;
        end else begin
          pos_q <= pos_q + 1'b1;
          if (in_magic && (byte_i != magic_byte)) magic_ok_q <= 1'b0;
          if (in_cmd) begin
            // only zero padding may follow the terminating zero
            if (zero_seen_q) begin
              if (byte_i != 8'h00) cmd_bad_q <= 1'b1;
            end else if (byte_i == 8'h00) begin
              zero_seen_q <= 1'b1;
            end else if (!printable) begin
              cmd_bad_q <= 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i && in_cmd) cmd_q[cmd_idx] <= byte_i;
    if (acc_i && in_len) len_q[len_lane] <= byte_i;
    if (acc_i && last_o) begin
      sum_q.magic_ok <= magic_ok_q;
      sum_q.cmd_bad  <= cmd_bad_q;
      sum_q.cls      <= cls_d;
      sum_q.length   <= {len_q[3], len_q[2], len_q[1], len_q[0]};
    end
  end

  assign sum_valid_o = sum_valid_q;
  assign sum_o       = sum_q;

endmodule

`default_nettype wire

[sv/p2p_blk_div.sv]
// Divides the block size by 215, one 16-bit digit at a time, most significant digit first.
`timescale 1ns / 1ps
`default_nettype none

module p2p_blk_div (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [47:0] dividend_i,
  output logic        done_o,
  output logic [47:0] quot_o
);

  localparam int unsigned DIGITS = 48 / p2p_pkg::DIG_W;
  localparam int unsigned PROD_W = p2p_pkg::DIV_NUM_W + p2p_pkg::DIV_RECIP_W;

  logic                            run_q;
  logic                            phase_q;
  logic                            done_q;
  logic [1:0]                      dig_q;
  logic [47:0]                     dvd_q;
  logic [47:0]                     quot_q;
  logic [7:0]                      rem_q;
  logic [p2p_pkg::DIV_NUM_W-1:0]   num_q;
  logic [p2p_pkg::DIG_W-1:0]       qd_q;

  logic [p2p_pkg::DIV_NUM_W-1:0]   num_d;
  logic [PROD_W-1:0]               prod;
  logic [p2p_pkg::DIV_NUM_W-1:0]   rem_d;

  // partial remainder stays below 215, so num_d < 215 * 2^16
  assign num_d = {rem_q, dvd_q[{dig_q, 4'b0000} +: p2p_pkg::DIG_W]};
  assign prod  = PROD_W'(num_d) * PROD_W'(p2p_pkg::DIV_RECIP);
  assign rem_d = num_q - p2p_pkg::DIV_NUM_W'(qd_q) * p2p_pkg::DIV_NUM_W'(p2p_pkg::MIN_TX_BYTES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      dig_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q   <= 1'b1;
        phase_q <= 1'b0;
        dig_q   <= 2'(DIGITS - 1);
      end else if (run_q) begin
        phase_q <= !phase_q;
        if (phase_q) begin
          if (dig_q == '0) begin
            run_q  <= 1'b0;
            done_q <= 1'b1;
          end else begin
            dig_q <= dig_q - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (run_q) begin
      if (!phase_q) begin
        qd_q  <= prod[p2p_pkg::DIV_SHIFT +: p2p_pkg::DIG_W];
        num_q <= num_d;
      end else begin
        rem_q  <= rem_d[7:0];
        quot_q <= {quot_q[47-p2p_pkg::DIG_W:0], qd_q};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire
